// ----- src/dcts_pkg.sv -----
// Package for the dependency counting task scheduler.
// Holds types, codes and default sizes shared by all modules; no dependencies.
`timescale 1ns / 1ps
package dcts_pkg;

  localparam int unsigned MaxTasksDefault = 64;
  localparam int unsigned MaxDependentsDefault = 8;
  localparam int unsigned MaxDependenciesDefault = 15;

  localparam int unsigned ModeW = 2;
  localparam int unsigned IdW = 6;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW = 7;

  typedef enum logic [ModeW-1:0] {
    MODE_ADD   = 2'd0,
    MODE_DONE  = 2'd1,
    MODE_FETCH = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_OVF   = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_WALK_RD,
    S_WALK_PD,
    S_WALK_EX,
    S_OUT
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the input transaction
    logic read;      // register per-task reads
    logic exec;      // perform add / fetch update
    logic walk_rd;   // read dependent k from the list
    logic walk_pd;   // read the pending count of dependent k
    logic walk_ex;   // decrement / enqueue dependent k
    logic out_load;  // load result register
  } dcts_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_walk;   // item is a completion
    logic walk_more; // dependent index below list length
  } dcts_sts_t;

endpackage

// ----- src/dcts_if.sv -----
// Valid/ready channel interfaces for the scheduler.
// Depends on dcts_pkg.
`timescale 1ns / 1ps
interface dcts_in_if;
  import dcts_pkg::*;
  logic           valid;
  logic           ready;
  logic [ModeW-1:0] mode;
  logic [IdW-1:0] task_id;
  logic [IdW-1:0] dep_id;
  logic           dep_valid;
  logic           last_dep;
  modport source (output valid, mode, task_id, dep_id, dep_valid, last_dep, input ready);
  modport sink (input valid, mode, task_id, dep_id, dep_valid, last_dep, output ready);
endinterface

interface dcts_out_if;
  import dcts_pkg::*;
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [IdW-1:0]     ready_task;
  logic [CountW-1:0]  ready_count;
  modport source (output valid, status, ready_task, ready_count, input ready);
  modport sink (input valid, status, ready_task, ready_count, output ready);
endinterface

// ----- src/dcts_ctrl.sv -----
// Controller state machine of the scheduler.
// Depends on dcts_pkg; drives dcts_datapath through cmd/sts structs.
`timescale 1ns / 1ps
module dcts_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  dcts_pkg::dcts_sts_t sts_i,
  output dcts_pkg::dcts_cmd_t cmd_o
);
  import dcts_pkg::*;

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    ovalid_d   = ovalid_q;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d = sts_i.is_walk ? S_WALK_RD : S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d = S_OUT;
      end
      S_WALK_RD: begin
        if (sts_i.walk_more) begin
          cmd_o.walk_rd = 1'b1;
          state_d = S_WALK_PD;
        end else begin
          state_d = S_OUT;
        end
      end
      S_WALK_PD: begin
        cmd_o.walk_pd = 1'b1;
        state_d = S_WALK_EX;
      end
      S_WALK_EX: begin
        cmd_o.walk_ex = 1'b1;
        state_d = S_WALK_RD;
      end
      S_OUT: begin
        // result register frees as soon as it is taken
        if (!ovalid_d) begin
          cmd_o.out_load = 1'b1;
          ovalid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = ovalid_q;
endmodule

// ----- src/dcts_datapath.sv -----
// Datapath of the scheduler: count, list and ready queue memories.
// Depends on dcts_pkg; commanded by dcts_ctrl.
`timescale 1ns / 1ps
module dcts_datapath #(
  parameter int unsigned MaxTasks = dcts_pkg::MaxTasksDefault,
  parameter int unsigned MaxDependents = dcts_pkg::MaxDependentsDefault,
  parameter int unsigned MaxDependencies = dcts_pkg::MaxDependenciesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [dcts_pkg::ModeW-1:0]    mode_i,
  input  logic [dcts_pkg::IdW-1:0]      task_id_i,
  input  logic [dcts_pkg::IdW-1:0]      dep_id_i,
  input  logic                          dep_valid_i,
  input  logic                          last_dep_i,
  input  dcts_pkg::dcts_cmd_t           cmd_i,
  output dcts_pkg::dcts_sts_t           sts_o,
  output logic [dcts_pkg::StatusW-1:0]  status_o,
  output logic [dcts_pkg::IdW-1:0]      ready_task_o,
  output logic [dcts_pkg::CountW-1:0]   ready_count_o
);
  import dcts_pkg::*;

  localparam int unsigned TW = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
  localparam int unsigned KW = (MaxDependents > 1) ? $clog2(MaxDependents) : 1;
  localparam int unsigned LW = $clog2(MaxDependents + 1);
  localparam int unsigned PW = $clog2(MaxDependencies + 1);
  localparam int unsigned FW = $clog2(MaxTasks + 1);
  localparam int unsigned LD = MaxTasks * (1 << KW);
  localparam int unsigned AW = TW + KW;
  localparam logic [PW-1:0] PMax = PW'(MaxDependencies);
  localparam logic [LW-1:0] LMax = LW'(MaxDependents);
  localparam logic [FW-1:0] FMax = FW'(MaxTasks);
  localparam logic [TW-1:0] TLast = TW'(MaxTasks - 1);

  // Per-task counts: memories, a written flag per task makes unwritten ones read zero
  logic [PW-1:0] pend_mem [MaxTasks];
  logic [LW-1:0] dlen_mem [MaxTasks];
  logic [MaxTasks-1:0] pend_vld_q, dlen_vld_q;
  // Stores undefined until written
  logic [TW-1:0] dlist_mem [LD];
  logic [TW-1:0] fifo_mem [MaxTasks];

  logic [TW-1:0] head_q, tail_q;
  logic [FW-1:0] fill_q;
  logic          run_open_q;

  // Captured transaction
  mode_e         mode_q;
  logic [TW-1:0] task_q, dep_q;
  logic          dv_q, last_q;
  // Registered reads
  logic [PW-1:0] pend_t_q, pend_w_q;
  logic          pend_tv_q, pend_wv_q;
  logic [LW-1:0] dlen_d_q, wlen_q;
  logic          dlen_dv_q, wlen_v_q;
  logic [LW-1:0] k_q;
  logic [TW-1:0] wdep_q, fifo_rd_q;
  logic [StatusW-1:0] st_q;
  logic [IdW-1:0]     rt_q;
  logic [StatusW-1:0] status_q;
  logic [IdW-1:0]     ready_task_q;
  logic [CountW-1:0]  ready_count_q;

  logic [PW-1:0] pend_t, pend_w, add_np;
  logic [LW-1:0] dlen_d, wlen;
  logic          add_ok, add_enq;
  logic [TW-1:0] head_nx, tail_nx;
  logic [AW-1:0] raddr;

  // Unwritten entries read as zero; a new run starts from zero
  assign pend_t = pend_tv_q ? pend_t_q : '0;
  assign pend_w = pend_wv_q ? pend_w_q : '0;
  assign dlen_d = dlen_dv_q ? dlen_d_q : '0;
  assign wlen   = wlen_v_q ? wlen_q : '0;

  // Add decision
  assign add_ok  = dv_q && pend_t < PMax && dlen_d < LMax;
  assign add_np  = add_ok ? pend_t + PW'(1) : pend_t;
  assign add_enq = last_q && add_np == '0;

  // Ring pointer wrap
  assign head_nx = (head_q == TLast) ? '0 : head_q + TW'(1);
  assign tail_nx = (tail_q == TLast) ? '0 : tail_q + TW'(1);

  assign sts_o.is_walk   = (mode_q == MODE_DONE);
  assign sts_o.walk_more = (k_q < wlen);
  assign raddr = {task_q, k_q[KW-1:0]};

  // Capture and registered reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mode_e'(mode_i);
      task_q <= TW'(task_id_i);
      dep_q  <= TW'(dep_id_i);
      dv_q   <= dep_valid_i;
      last_q <= last_dep_i;
    end
    if (cmd_i.read) begin
      pend_t_q  <= pend_mem[task_q];
      pend_tv_q <= run_open_q & pend_vld_q[task_q];
      dlen_d_q  <= dlen_mem[dep_q];
      dlen_dv_q <= dlen_vld_q[dep_q];
      wlen_q    <= dlen_mem[task_q];
      wlen_v_q  <= dlen_vld_q[task_q];
      fifo_rd_q <= fifo_mem[head_q];
    end
    if (cmd_i.walk_rd) wdep_q <= dlist_mem[raddr];
    if (cmd_i.walk_pd) begin
      pend_w_q  <= pend_mem[wdep_q];
      pend_wv_q <= pend_vld_q[wdep_q];
    end
  end

  // Memory writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && mode_q == MODE_ADD) begin
      pend_mem[task_q] <= add_np;
      if (add_ok) begin
        dlen_mem[dep_q] <= dlen_d + LW'(1);
        dlist_mem[{dep_q, dlen_d[KW-1:0]}] <= task_q;
      end
      if (add_enq && fill_q < FMax) fifo_mem[tail_q] <= task_q;
    end
    if (cmd_i.walk_ex && pend_w != '0) begin
      pend_mem[wdep_q] <= pend_w - PW'(1);
      if (pend_w == PW'(1) && fill_q < FMax) fifo_mem[tail_q] <= wdep_q;
    end
  end

  // Control and count state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= '0;
      dlen_vld_q <= '0;
      head_q <= '0; tail_q <= '0; fill_q <= '0; run_open_q <= 1'b0;
      k_q <= '0; st_q <= ST_OK; rt_q <= '0;
      status_q <= ST_OK; ready_task_q <= '0; ready_count_q <= '0;
    end else begin
      if (cmd_i.read) begin
        k_q <= '0; st_q <= ST_OK; rt_q <= '0;
      end
      if (cmd_i.exec) begin
        case (mode_q)
          MODE_ADD: begin
            if ((dv_q && !add_ok) || (add_enq && fill_q >= FMax)) st_q <= ST_OVF;
            if (add_ok) dlen_vld_q[dep_q] <= 1'b1;
            pend_vld_q[task_q] <= 1'b1;
            run_open_q <= !last_q;
            if (add_enq && fill_q < FMax) begin
              tail_q <= tail_nx;
              fill_q <= fill_q + FW'(1);
            end
          end
          MODE_FETCH: begin
            if (fill_q == '0) st_q <= ST_EMPTY;
            else begin
              rt_q   <= IdW'(fifo_rd_q);
              head_q <= head_nx;
              fill_q <= fill_q - FW'(1);
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.walk_ex) begin
        k_q <= k_q + LW'(1);
        if (pend_w == PW'(1)) begin
          if (fill_q < FMax) begin
            tail_q <= tail_nx;
            fill_q <= fill_q + FW'(1);
          end else begin
            st_q <= ST_OVF;
          end
        end
      end
      if (cmd_i.out_load) begin
        status_q      <= st_q;
        ready_task_q  <= rt_q;
        ready_count_q <= CountW'(fill_q);
      end
    end
  end

  assign status_o      = status_q;
  assign ready_task_o  = ready_task_q;
  assign ready_count_o = ready_count_q;
endmodule

// ----- src/dependency_counting_task_scheduler_unit.sv -----
// Top level of the dependency counting task scheduler.
// Depends on dcts_pkg, dcts_if, dcts_ctrl and dcts_datapath.
`timescale 1ns / 1ps
// One transaction at a time, one result per transaction. An add, fetch or
// unused-mode transaction passes through the read, execute and output states
// before the next one can be taken; a completion, between its read and output
// states, walks the completed task's dependents list (at most MaxDependents
// entries), per dependent reading the list entry, then its count, then
// updating that count. A new transaction is taken once the previous result
// has been loaded into the output register; a result left waiting there
// holds the unit. Task ids are truncated to their low $clog2(MaxTasks) bits;
// no clearing pass is needed after reset.
module dependency_counting_task_scheduler_unit #(
  parameter int unsigned MaxTasks = dcts_pkg::MaxTasksDefault,
  parameter int unsigned MaxDependents = dcts_pkg::MaxDependentsDefault,
  parameter int unsigned MaxDependencies = dcts_pkg::MaxDependenciesDefault
) (
  input logic     clk_i,
  input logic     rst_ni,
  dcts_in_if.sink   in_i,
  dcts_out_if.source out_o
);
  import dcts_pkg::*;

  dcts_cmd_t cmd;
  dcts_sts_t sts;

  dcts_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dcts_datapath #(
    .MaxTasks(MaxTasks), .MaxDependents(MaxDependents),
    .MaxDependencies(MaxDependencies)
  ) u_dp (
    .clk_i, .rst_ni,
    .mode_i       (in_i.mode),
    .task_id_i    (in_i.task_id),
    .dep_id_i     (in_i.dep_id),
    .dep_valid_i  (in_i.dep_valid),
    .last_dep_i   (in_i.last_dep),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .status_o     (out_o.status),
    .ready_task_o (out_o.ready_task),
    .ready_count_o(out_o.ready_count)
  );
endmodule
